// ===== design/ixfs_pkg.sv =====
package ixfs_pkg;

  // fixed field widths of the item ports
  localparam int IDX_W  = 10;
  localparam int CNT_W  = 11;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;

  // item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TAKE      = 2'd0,
    KIND_RELEASE   = 2'd1,
    KIND_SET_LIMIT = 2'd2,
    KIND_CLEAR     = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 2'd0,
    ST_NONE_LEFT    = 2'd1,
    ST_OUT_OF_RANGE = 2'd2,
    ST_STACK_FULL   = 2'd3
  } status_t;

  // controller states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_WALK = 3'b100
  } state_t;

endpackage

// ===== design/ixfs_ram.sv =====
module ixfs_ram #(
  parameter int DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [ixfs_pkg::IDX_W-1:0]   wdata,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [ixfs_pkg::IDX_W-1:0]   rdata
);

  logic [ixfs_pkg::IDX_W-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/index_allocator_free_stack.sv =====
// Free-list index allocator with a LIFO recycle stack held in one synchronous
// RAM of MAX_INDICES entries. An item is taken on start while busy is low; its
// result is registered and appears in the cycle after its work ends, for exactly
// one cycle, marked by done, and cannot be held off by the receiver. Release,
// clear and a take served from the fresh counter are done in the cycle of start
// and leave busy low. A take served from the stack passes through S_POP to wait
// for the registered read of the stack RAM. A set-limit item walks the stack in
// S_WALK through the single read and write port. Writing initial_limit while
// idle empties the stack, zeroes the fresh counter and loads the limit,
// saturated at MAX_INDICES; it wins over a start in the same cycle.
// No clearing pass is needed after reset: stack entries are only used below
// the stack count.
module index_allocator_free_stack #(
  parameter int MAX_INDICES = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          initial_limit_we,
  input  logic [ixfs_pkg::CNT_W-1:0]    initial_limit,
  input  logic                          start,
  output logic                          busy,
  input  logic [ixfs_pkg::KIND_W-1:0]   kind,
  input  logic [ixfs_pkg::IDX_W-1:0]    index_value,
  input  logic [ixfs_pkg::CNT_W-1:0]    new_limit,
  output logic                          done,
  output logic [ixfs_pkg::IDX_W-1:0]    granted_index,
  output logic                          granted,
  output logic [ixfs_pkg::STAT_W-1:0]   status,
  output logic [ixfs_pkg::CNT_W-1:0]    free_count
);

  localparam int IW = ixfs_pkg::IDX_W;
  localparam int NW = ixfs_pkg::CNT_W;
  localparam int AW = $clog2(MAX_INDICES);
  localparam int CW = $clog2(MAX_INDICES + 1);
  localparam int LW = (CW > NW) ? CW : NW;
  localparam int RESET_LIMIT = (MAX_INDICES < 1024) ? MAX_INDICES : 1024;

  // saturate a limit at the stack depth
  function automatic logic [LW-1:0] clamp_limit(input logic [NW-1:0] v);
    logic [LW-1:0] ext;
    ext = LW'(v);
    if (ext > LW'(MAX_INDICES)) begin
      return LW'(MAX_INDICES);
    end
    return ext;
  endfunction

  ixfs_pkg::state_t  state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [LW-1:0]     fresh, fresh_next;
  logic [LW-1:0]     limit, limit_next;
  logic [LW-1:0]     walk_limit, walk_limit_next;
  logic [CW-1:0]     rd_ptr, rd_ptr_next;
  logic [CW-1:0]     wr_ptr, wr_ptr_next;
  logic              pend, pend_next;

  logic              res_valid;
  logic [IW-1:0]     res_index;
  logic              res_granted;
  ixfs_pkg::status_t res_status;
  ixfs_pkg::status_t status_q;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [IW-1:0]     mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [IW-1:0]     mem_rdata;

  ixfs_ram #(
    .DEPTH (MAX_INDICES)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy = (state != ixfs_pkg::S_IDLE);

  // item sequencing and stack read-modify-write
  always_comb begin
    state_next      = state;
    count_next      = count;
    fresh_next      = fresh;
    limit_next      = limit;
    walk_limit_next = walk_limit;
    rd_ptr_next     = rd_ptr;
    wr_ptr_next     = wr_ptr;
    pend_next       = pend;
    res_valid       = 1'b0;
    res_index       = '0;
    res_granted     = 1'b0;
    res_status      = ixfs_pkg::ST_OK;
    mem_we          = 1'b0;
    mem_waddr       = count[AW-1:0];
    mem_wdata       = index_value;
    mem_raddr       = rd_ptr[AW-1:0];
    unique case (state)
      ixfs_pkg::S_IDLE: begin
        // top of stack, read ahead for a pop
        mem_raddr = AW'(count - CW'(1));
        if (initial_limit_we) begin
          count_next = '0;
          fresh_next = '0;
          limit_next = clamp_limit(initial_limit);
        end else if (start) begin
          case (ixfs_pkg::kind_t'(kind))
            ixfs_pkg::KIND_TAKE: begin
              if (count != '0) begin
                count_next = count - CW'(1);
                state_next = ixfs_pkg::S_POP;
              end else if (fresh < limit) begin
                res_valid   = 1'b1;
                res_index   = IW'(fresh);
                res_granted = 1'b1;
                fresh_next  = fresh + LW'(1);
              end else begin
                res_valid  = 1'b1;
                res_status = ixfs_pkg::ST_NONE_LEFT;
              end
            end
            ixfs_pkg::KIND_RELEASE: begin
              res_valid = 1'b1;
              if (LW'(index_value) >= limit) begin
                res_status = ixfs_pkg::ST_OUT_OF_RANGE;
              end else if (count == CW'(MAX_INDICES)) begin
                res_status = ixfs_pkg::ST_STACK_FULL;
              end else begin
                mem_we     = 1'b1;
                count_next = count + CW'(1);
              end
            end
            ixfs_pkg::KIND_SET_LIMIT: begin
              walk_limit_next = clamp_limit(new_limit);
              rd_ptr_next     = '0;
              wr_ptr_next     = '0;
              pend_next       = 1'b0;
              state_next      = ixfs_pkg::S_WALK;
            end
            default: begin
              // clear
              res_valid  = 1'b1;
              count_next = '0;
              fresh_next = '0;
            end
          endcase
        end
      end
      ixfs_pkg::S_POP: begin
        res_valid   = 1'b1;
        res_index   = mem_rdata;
        res_granted = 1'b1;
        state_next  = ixfs_pkg::S_IDLE;
      end
      ixfs_pkg::S_WALK: begin
        // keep the entry read last cycle if below the new limit
        if (pend && (LW'(mem_rdata) < walk_limit)) begin
          mem_we      = 1'b1;
          mem_waddr   = wr_ptr[AW-1:0];
          mem_wdata   = mem_rdata;
          wr_ptr_next = wr_ptr + CW'(1);
        end
        // issue the next read, or finish once the last entry is handled
        if (rd_ptr != count) begin
          rd_ptr_next = rd_ptr + CW'(1);
          pend_next   = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            count_next = wr_ptr;
            if (fresh > walk_limit) begin
              fresh_next = walk_limit;
            end
            limit_next = walk_limit;
            res_valid  = 1'b1;
            state_next = ixfs_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = ixfs_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ixfs_pkg::S_IDLE;
      count  <= '0;
      fresh  <= '0;
      limit  <= LW'(RESET_LIMIT);
      pend   <= 1'b0;
      rd_ptr <= '0;
      wr_ptr <= '0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      fresh  <= fresh_next;
      limit  <= limit_next;
      pend   <= pend_next;
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    walk_limit <= walk_limit_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      granted_index <= res_index;
      granted       <= res_granted;
      status_q      <= res_status;
      free_count    <= NW'(count_next);
    end
  end

  assign status = status_q;

  // a pop finishes in the cycle after the stack read
  a_pop_one: assert property (@(posedge clk) disable iff (rst)
    state == ixfs_pkg::S_POP |=> state == ixfs_pkg::S_IDLE && done)
    else $error("pop did not complete in one cycle");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_INDICES))
    else $error("stack count beyond depth");

  a_fresh_limit: assert property (@(posedge clk) disable iff (rst)
    fresh <= limit)
    else $error("fresh counter above limit");

  // compaction never writes ahead of what it has read
  a_walk_ptrs: assert property (@(posedge clk) disable iff (rst)
    state == ixfs_pkg::S_WALK |-> wr_ptr <= rd_ptr && rd_ptr <= count)
    else $error("walk pointers out of order");

endmodule
